FILE: sv/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared constants and types of the touch sample filter
// Group size, trim depth, divider constants, op and register codes, and the
// command, status, configuration and result structs.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int unsigned SAMPLES  = 5;
  localparam int unsigned DROP     = 1;
  localparam int unsigned DROP_EFF = (DROP > (SAMPLES - 1) / 2) ? (SAMPLES - 1) / 2 : DROP;
  localparam int unsigned KEEP     = SAMPLES - 2 * DROP_EFF;

  localparam int unsigned SMP_W  = 12;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned GAIN_W = 19;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned CNT_W  = $clog2(SAMPLES);
  localparam int unsigned SUM_W  = SMP_W + $clog2(KEEP);
  localparam int unsigned DIV_SH = SUM_W;
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PRD_W  = SUM_W + RCP_W;
  localparam int unsigned CAL_W  = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [RCP_W-1:0] DIV_RCP   = RCP_W'((1 << DIV_SH) / KEEP);
  localparam logic [SUM_W-1:0] KEEP_V    = SUM_W'(KEEP);
  localparam logic [CNT_W-1:0] SUM_FIRST = CNT_W'(DROP_EFF);
  localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(SAMPLES - 1 - DROP_EFF);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SAMPLES - 1);

  localparam logic [POS_W-1:0] IDLE_POS = 16'h00ff;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_PEN_UP = 2'd1;
  localparam logic [1:0] OP_ACK    = 2'd2;

  localparam logic [1:0] GRP_X1 = 2'd0;
  localparam logic [1:0] GRP_Y1 = 2'd1;
  localparam logic [1:0] GRP_X2 = 2'd2;
  localparam logic [1:0] GRP_Y2 = 2'd3;

  localparam logic [2:0] REG_RAW_MODE     = 3'd0;
  localparam logic [2:0] REG_AGREE_WINDOW = 3'd1;
  localparam logic [2:0] REG_X_GAIN       = 3'd2;
  localparam logic [2:0] REG_X_OFFSET     = 3'd3;
  localparam logic [2:0] REG_Y_GAIN       = 3'd4;
  localparam logic [2:0] REG_Y_OFFSET     = 3'd5;

  localparam logic [SMP_W-1:0]  RST_AGREE_WINDOW = 12'd50;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 19'd65536;

  typedef struct packed {
    logic                     raw_mode;
    logic [SMP_W-1:0]         agree_window;
    logic signed [GAIN_W-1:0] x_gain;
    logic signed [OFS_W-1:0]  x_offset;
    logic signed [GAIN_W-1:0] y_gain;
    logic signed [OFS_W-1:0]  y_offset;
  } tsf_cfg_t;

  typedef struct packed {
    logic insert;
    logic pen_up;
    logic ack;
    logic sum_start;
    logic sum_add;
    logic div_mul;
    logic div_fix;
    logic agree;
    logic cal_x;
    logic cal_y;
    logic cal_fin;
    logic press;
    logic load_out;
  } tsf_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic sum_done;
    logic last_group;
    logic ok;
    logic raw;
    logic out_free;
  } tsf_sts_t;

  typedef struct packed {
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [POS_W-1:0] first_x;
    logic [POS_W-1:0] first_y;
    logic             pen_down;
    logic             caught;
    logic             reading_ok;
  } tsf_res_t;

endpackage

FILE: sv/tsf_in_if.sv
// ----------------------------------------------------------------------------
// tsf_in_if: input channel of the touch sample filter
// Valid/ready channel carrying one op code and one converter sample.
// ----------------------------------------------------------------------------
interface tsf_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [tsf_pkg::SMP_W-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

FILE: sv/tsf_out_if.sv
// ----------------------------------------------------------------------------
// tsf_out_if: result channel of the touch sample filter
// Valid/ready channel carrying coordinates and press status.
// ----------------------------------------------------------------------------
interface tsf_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsf_pkg::POS_W-1:0] x_pos;
  logic [tsf_pkg::POS_W-1:0] y_pos;
  logic [tsf_pkg::POS_W-1:0] first_x;
  logic [tsf_pkg::POS_W-1:0] first_y;
  logic                      pen_down;
  logic                      caught;
  logic                      reading_ok;

  modport source (output valid, output x_pos, output y_pos, output first_x, output first_y,
                  output pen_down, output caught, output reading_ok, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input first_x, input first_y,
                  input pen_down, input caught, input reading_ok, output ready);
endinterface

FILE: sv/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl: sequencer of the touch sample filter
// Takes ops in idle, then steps the datapath through group sum, divide,
// agreement check, calibration, press update and result load.
// ----------------------------------------------------------------------------
module tsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  tsf_pkg::tsf_sts_t sts,
  output tsf_pkg::tsf_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_FIX   = 4'd3;
  localparam logic [3:0] S_AGREE = 4'd4;
  localparam logic [3:0] S_CALX  = 4'd5;
  localparam logic [3:0] S_CLX   = 4'd6;
  localparam logic [3:0] S_CLY   = 4'd7;
  localparam logic [3:0] S_PRESS = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            tsf_pkg::OP_SAMPLE: begin
              cmd.insert = 1'b1;
              if (sts.last_sample) begin
                cmd.sum_start = 1'b1;
                state_next    = S_SUM;
              end
            end
            tsf_pkg::OP_PEN_UP: begin
              cmd.pen_up = 1'b1;
              state_next = S_EMIT;
            end
            tsf_pkg::OP_ACK: begin
              cmd.ack    = 1'b1;
              state_next = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        if (sts.sum_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_mul = 1'b1;
        state_next  = S_FIX;
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = sts.last_group ? S_AGREE : S_IDLE;
      end
      S_AGREE: begin
        cmd.agree  = 1'b1;
        state_next = S_CALX;
      end
      S_CALX: begin
        if (sts.ok) begin
          cmd.cal_x  = 1'b1;
          state_next = sts.raw ? S_PRESS : S_CLX;
        end else begin
          state_next = S_PRESS;
        end
      end
      S_CLX: begin
        cmd.cal_y  = 1'b1;
        state_next = S_CLY;
      end
      S_CLY: begin
        cmd.cal_fin = 1'b1;
        state_next  = S_PRESS;
      end
      S_PRESS: begin
        cmd.press  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sv/tsf_dp.sv
// ----------------------------------------------------------------------------
// tsf_dp: datapath of the touch sample filter
// Sorted group buffer with insertion cells, trimmed sum accumulator,
// reciprocal divider, agreement check, calibration multiplier, press state
// and the output register.
// ----------------------------------------------------------------------------
module tsf_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tsf_pkg::SMP_W-1:0] sample,
  input  tsf_pkg::tsf_cfg_t         cfg,
  input  tsf_pkg::tsf_cmd_t         cmd,
  output tsf_pkg::tsf_sts_t         sts,
  output tsf_pkg::tsf_res_t         res,
  output logic                      res_valid,
  input  logic                      res_ready
);

  localparam int unsigned SMP_W = tsf_pkg::SMP_W;
  localparam int unsigned POS_W = tsf_pkg::POS_W;
  localparam int unsigned SUM_W = tsf_pkg::SUM_W;
  localparam int unsigned CNT_W = tsf_pkg::CNT_W;
  localparam int unsigned CAL_W = tsf_pkg::CAL_W;
  localparam int unsigned NS    = tsf_pkg::SAMPLES;

  logic [SMP_W-1:0]            grp_buf [NS];
  logic [SMP_W-1:0]            ins_buf [NS];
  logic [NS-1:0]               gt;
  logic [CNT_W-1:0]            count;
  logic [1:0]                  group;
  logic [CNT_W-1:0]            idx;
  logic [SUM_W-1:0]            acc;
  logic [tsf_pkg::PRD_W-1:0]   div_prod;
  logic [SUM_W-1:0]            q0;
  logic [SUM_W-1:0]            rem;
  logic [SUM_W-1:0]            q_fix;
  logic [SMP_W-1:0]            mean;
  logic [SMP_W-1:0]            rd_x1;
  logic [SMP_W-1:0]            rd_y1;
  logic [SMP_W-1:0]            rd_x2;
  logic [SMP_W-1:0]            rd_y2;
  logic [SMP_W:0]              sum_x;
  logic [SMP_W:0]              sum_y;
  logic [SMP_W-1:0]            avg_x;
  logic [SMP_W-1:0]            avg_y;
  logic                        ok;
  logic signed [CAL_W-1:0]     cal_prod;
  logic [POS_W-1:0]            cur_x;
  logic [POS_W-1:0]            cur_y;
  logic [POS_W-1:0]            press_x;
  logic [POS_W-1:0]            press_y;
  logic                        pressed;
  logic                        caught;

  function automatic logic agree(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
                                 input logic [SMP_W-1:0] win);
    logic [SMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < win;
  endfunction

  function automatic logic [POS_W-1:0] cal_clip(input logic signed [CAL_W-1:0] p,
                                                input logic signed [tsf_pkg::OFS_W-1:0] ofs);
    logic signed [CAL_W:0] t;
    t = (CAL_W + 1)'(p) + (CAL_W + 1)'($signed({ofs, 16'h0000}));
    return t[CAL_W] ? '0 : t[CAL_W-1:CAL_W-POS_W];
  endfunction

  // insertion cells: each entry compares against the new sample
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      gt[i] = (CNT_W'(i) >= count) || (grp_buf[i] > sample);
    end
    ins_buf[0] = gt[0] ? sample : grp_buf[0];
    for (int i = 1; i < NS; i++) begin
      ins_buf[i] = gt[i] ? (gt[i-1] ? grp_buf[i-1] : sample) : grp_buf[i];
    end
  end

  // floor reciprocal gives the quotient or one less
  always_comb begin
    q0    = div_prod[tsf_pkg::DIV_SH +: SUM_W];
    rem   = acc - SUM_W'(q0 * tsf_pkg::KEEP_V);
    q_fix = (rem >= tsf_pkg::KEEP_V) ? (q0 + 1'b1) : q0;
    mean  = q_fix[SMP_W-1:0];
    sum_x = {1'b0, rd_x1} + {1'b0, rd_x2};
    sum_y = {1'b0, rd_y1} + {1'b0, rd_y2};
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < NS; i++) begin
        grp_buf[i] <= ins_buf[i];
      end
    end
    if (cmd.sum_start) begin
      idx <= tsf_pkg::SUM_FIRST;
      acc <= '0;
    end else if (cmd.sum_add) begin
      idx <= idx + 1'b1;
      acc <= acc + SUM_W'(grp_buf[idx]);
    end
    if (cmd.div_mul) begin
      div_prod <= tsf_pkg::PRD_W'(acc) * tsf_pkg::PRD_W'(tsf_pkg::DIV_RCP);
    end
    if (cmd.div_fix) begin
      case (group)
        tsf_pkg::GRP_X1: rd_x1 <= mean;
        tsf_pkg::GRP_Y1: rd_y1 <= mean;
        tsf_pkg::GRP_X2: rd_x2 <= mean;
        default:         rd_y2 <= mean;
      endcase
    end
    if (cmd.agree) begin
      avg_x <= sum_x[SMP_W:1];
      avg_y <= sum_y[SMP_W:1];
    end
    if (cmd.cal_x && !cfg.raw_mode) begin
      cal_prod <= CAL_W'(cfg.x_gain) * CAL_W'($signed({1'b0, avg_x}));
    end else if (cmd.cal_y) begin
      cal_prod <= CAL_W'(cfg.y_gain) * CAL_W'($signed({1'b0, avg_y}));
    end
    if (cmd.load_out) begin
      res <= '{x_pos: cur_x, y_pos: cur_y, first_x: press_x, first_y: press_y,
               pen_down: pressed, caught: caught, reading_ok: ok};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      group     <= tsf_pkg::GRP_X1;
      ok        <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      press_x   <= '0;
      press_y   <= '0;
      pressed   <= 1'b0;
      caught    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= (count == tsf_pkg::CNT_LAST) ? '0 : count + 1'b1;
      end
      if (cmd.div_fix) begin
        group <= group + 1'b1;
      end
      if (cmd.pen_up) begin
        count <= '0;
        group <= tsf_pkg::GRP_X1;
        ok    <= 1'b0;
        if (pressed) begin
          pressed <= 1'b0;
        end else begin
          press_x <= '0;
          press_y <= '0;
          cur_x   <= tsf_pkg::IDLE_POS;
          cur_y   <= tsf_pkg::IDLE_POS;
        end
      end
      if (cmd.ack) begin
        caught <= 1'b0;
        ok     <= 1'b0;
      end
      if (cmd.agree) begin
        ok <= agree(rd_x1, rd_x2, cfg.agree_window) && agree(rd_y1, rd_y2, cfg.agree_window);
      end
      if (cmd.cal_x && cfg.raw_mode) begin
        cur_x <= POS_W'(avg_x);
        cur_y <= POS_W'(avg_y);
      end
      if (cmd.cal_y) begin
        cur_x <= cal_clip(cal_prod, cfg.x_offset);
      end
      if (cmd.cal_fin) begin
        cur_y <= cal_clip(cal_prod, cfg.y_offset);
      end
      if (cmd.press && !pressed) begin
        pressed <= 1'b1;
        caught  <= 1'b1;
        press_x <= cur_x;
        press_y <= cur_y;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign sts.last_sample = (count == tsf_pkg::CNT_LAST);
  assign sts.sum_done    = (idx == tsf_pkg::SUM_LAST);
  assign sts.last_group  = (group == tsf_pkg::GRP_Y2);
  assign sts.ok          = ok;
  assign sts.raw         = cfg.raw_mode;
  assign sts.out_free    = !res_valid || res_ready;

endmodule

FILE: sv/touch_sample_filter_unit.sv
// ----------------------------------------------------------------------------
// touch_sample_filter_unit: trimmed-mean touch filter and press tracker
// Input channel req carries an op (sample, pen up, acknowledge) and a 12-bit
// converter sample; result channel rsp carries coordinates and press flags.
// Samples come as four groups (x, y, x, y) of five; each group is sorted on
// arrival, trimmed and averaged. A sample that does not end a group is only
// inserted; the last sample of a group is inserted, then goes through three
// accumulate steps over the kept entries, one reciprocal multiply and one
// correction. The last sample of a scan adds the agreement check, calibration
// on the one multiplier when the readings agree, the press update and the
// result load; pen up and acknowledge go straight to the result load.
// A result sits in an output register, so the next sample is taken while it
// waits; when the receiver stalls, the next result holds the block in its
// load step and no item is taken until the register frees.
// Configuration is an APB port, register i at byte address 4*i, with no
// wait states. Synchronous reset loads the register defaults and clears the
// press state, coordinates, group position and the output valid flag.
// ----------------------------------------------------------------------------
module touch_sample_filter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsf_pkg::ADDR_W-1:0] paddr,
  input  logic [tsf_pkg::DATA_W-1:0] pwdata,
  output logic [tsf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  tsf_in_if.sink                     req,
  tsf_out_if.source                  rsp
);

  tsf_pkg::tsf_cfg_t cfg;
  tsf_pkg::tsf_cmd_t cmd;
  tsf_pkg::tsf_sts_t sts;
  tsf_pkg::tsf_res_t res;
  logic [2:0]        reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[tsf_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_mode     <= 1'b0;
      cfg.agree_window <= tsf_pkg::RST_AGREE_WINDOW;
      cfg.x_gain       <= tsf_pkg::RST_GAIN;
      cfg.x_offset     <= '0;
      cfg.y_gain       <= tsf_pkg::RST_GAIN;
      cfg.y_offset     <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        tsf_pkg::REG_RAW_MODE:     cfg.raw_mode     <= pwdata[0];
        tsf_pkg::REG_AGREE_WINDOW: cfg.agree_window <= pwdata[tsf_pkg::SMP_W-1:0];
        tsf_pkg::REG_X_GAIN:       cfg.x_gain       <= pwdata[tsf_pkg::GAIN_W-1:0];
        tsf_pkg::REG_X_OFFSET:     cfg.x_offset     <= pwdata[tsf_pkg::OFS_W-1:0];
        tsf_pkg::REG_Y_GAIN:       cfg.y_gain       <= pwdata[tsf_pkg::GAIN_W-1:0];
        tsf_pkg::REG_Y_OFFSET:     cfg.y_offset     <= pwdata[tsf_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tsf_pkg::REG_RAW_MODE:     prdata = tsf_pkg::DATA_W'(cfg.raw_mode);
      tsf_pkg::REG_AGREE_WINDOW: prdata = tsf_pkg::DATA_W'(cfg.agree_window);
      tsf_pkg::REG_X_GAIN:       prdata = tsf_pkg::DATA_W'(cfg.x_gain);
      tsf_pkg::REG_X_OFFSET:     prdata = tsf_pkg::DATA_W'(cfg.x_offset);
      tsf_pkg::REG_Y_GAIN:       prdata = tsf_pkg::DATA_W'(cfg.y_gain);
      tsf_pkg::REG_Y_OFFSET:     prdata = tsf_pkg::DATA_W'(cfg.y_offset);
      default:                   prdata = '0;
    endcase
  end

  tsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (req.sample),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res),
    .res_valid (rsp.valid),
    .res_ready (rsp.ready)
  );

  assign rsp.x_pos      = res.x_pos;
  assign rsp.y_pos      = res.y_pos;
  assign rsp.first_x    = res.first_x;
  assign rsp.first_y    = res.first_y;
  assign rsp.pen_down   = res.pen_down;
  assign rsp.caught     = res.caught;
  assign rsp.reading_ok = res.reading_ok;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp.valid)
    else $error("loaded result not presented");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.insert, cmd.pen_up, cmd.ack, cmd.sum_add, cmd.div_mul, cmd.div_fix,
              cmd.agree, cmd.cal_x, cmd.cal_y, cmd.cal_fin, cmd.press, cmd.load_out}))
    else $error("more than one datapath step in a cycle");
`endif

endmodule

FILE: tb/tb_touch_sample_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_touch_sample_filter_unit: self-checking bench for the touch sample filter
// A driver feeds op/sample transfers from a queue, a monitor predicts every
// report from the accepted transfers and compares it field by field with the
// block's output. Filter settings change over the APB port between phases,
// with random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_touch_sample_filter_unit;
  import tsf_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_GAP   = 30;

  typedef struct packed {
    logic [1:0]       op;
    logic [SMP_W-1:0] sample;
  } touch_item_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tsf_in_if  req_ch ();
  tsf_out_if rsp_ch ();

  touch_sample_filter_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  touch_item_t pending_items[$];
  tsf_res_t    expected_reports[$];
  int          queued_items  = 0;
  int          errors        = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          recv_hold     = 1'b0;
  bit          in_xfer       = 1'b0;
  bit          drained       = 1'b0;

  // filter model state
  tsf_cfg_t         cfg_model = '{raw_mode: 1'b0, agree_window: RST_AGREE_WINDOW,
                                  x_gain: RST_GAIN, x_offset: '0,
                                  y_gain: RST_GAIN, y_offset: '0};
  logic [SMP_W-1:0] grp_buf [SAMPLES];
  int               fill_cnt    = 0;
  logic [1:0]       grp_sel     = GRP_X1;
  logic [SMP_W-1:0] x_rd1       = '0;
  logic [SMP_W-1:0] y_rd1       = '0;
  logic [SMP_W-1:0] x_rd2       = '0;
  logic [POS_W-1:0] cur_x       = '0;
  logic [POS_W-1:0] cur_y       = '0;
  logic [POS_W-1:0] press_x     = '0;
  logic [POS_W-1:0] press_y     = '0;
  logic             pen_pressed = 1'b0;
  logic             caught_q    = 1'b0;

  int directed_scan [20] = '{4095, 100, 0, 102, 101,
                             2000, 2001, 4095, 0, 1999,
                             110, 0, 4095, 108, 109,
                             2010, 4095, 2008, 0, 2009};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [SMP_W-1:0] trimmed_mean();
    int v [SAMPLES];
    int i, j, key, total;
    for (i = 0; i < SAMPLES; i++) v[i] = grp_buf[i];
    for (i = 1; i < SAMPLES; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    total = 0;
    for (i = DROP_EFF; i < SAMPLES - DROP_EFF; i++) total += v[i];
    return SMP_W'(total / KEEP);
  endfunction

  function automatic bit within_window(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d < int'(cfg_model.agree_window);
  endfunction

  function automatic logic [POS_W-1:0] to_screen(logic [SMP_W-1:0] v,
                                                 logic signed [GAIN_W-1:0] gain,
                                                 logic signed [OFS_W-1:0] ofs);
    longint t;
    t = longint'(gain) * longint'({1'b0, v}) + longint'(ofs) * 65536;
    if (t < 0) return '0;
    t = t >>> 16;
    return (t > 65535) ? 16'hffff : POS_W'(t);
  endfunction

  task automatic queue_report(input logic ok);
    expected_reports.push_back('{x_pos: cur_x, y_pos: cur_y, first_x: press_x,
                                 first_y: press_y, pen_down: pen_pressed,
                                 caught: caught_q, reading_ok: ok});
  endtask

  task automatic track_touch(input logic [1:0] op, input logic [SMP_W-1:0] smp);
    logic [SMP_W-1:0] mean;
    logic [SMP_W:0]   ax, ay;
    logic             ok;
    ok = 1'b0;
    case (op)
      OP_PEN_UP: begin
        fill_cnt = 0;
        grp_sel = GRP_X1;
        if (pen_pressed) begin
          pen_pressed = 1'b0;
        end else begin
          press_x = '0;
          press_y = '0;
          cur_x = IDLE_POS;
          cur_y = IDLE_POS;
        end
        queue_report(1'b0);
      end
      OP_ACK: begin
        caught_q = 1'b0;
        queue_report(1'b0);
      end
      OP_SAMPLE: begin
        grp_buf[fill_cnt] = smp;
        fill_cnt++;
        if (fill_cnt == SAMPLES) begin
          fill_cnt = 0;
          mean = trimmed_mean();
          case (grp_sel)
            GRP_X1: x_rd1 = mean;
            GRP_Y1: y_rd1 = mean;
            GRP_X2: x_rd2 = mean;
            default: begin
              if (within_window(x_rd1, x_rd2) && within_window(y_rd1, mean)) begin
                ax = ({1'b0, x_rd1} + {1'b0, x_rd2}) >> 1;
                ay = ({1'b0, y_rd1} + {1'b0, mean}) >> 1;
                if (cfg_model.raw_mode) begin
                  cur_x = POS_W'(ax);
                  cur_y = POS_W'(ay);
                end else begin
                  cur_x = to_screen(ax[SMP_W-1:0], cfg_model.x_gain, cfg_model.x_offset);
                  cur_y = to_screen(ay[SMP_W-1:0], cfg_model.y_gain, cfg_model.y_offset);
                end
                ok = 1'b1;
              end
              if (!pen_pressed) begin
                pen_pressed = 1'b1;
                caught_q = 1'b1;
                press_x = cur_x;
                press_y = cur_y;
              end
              queue_report(ok);
            end
          endcase
          grp_sel = grp_sel + 2'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // monitor: check reports, then predict from the accepted input transfer
  always @(posedge clk) begin
    tsf_res_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("report transfer with no report pending");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("x_pos", want.x_pos, rsp_ch.x_pos);
          check_field("y_pos", want.y_pos, rsp_ch.y_pos);
          check_field("first_x", want.first_x, rsp_ch.first_x);
          check_field("first_y", want.first_y, rsp_ch.first_y);
          check_field("pen_down", POS_W'(want.pen_down), POS_W'(rsp_ch.pen_down));
          check_field("caught", POS_W'(want.caught), POS_W'(rsp_ch.caught));
          check_field("reading_ok", POS_W'(want.reading_ok), POS_W'(rsp_ch.reading_ok));
        end
      end
      in_xfer = req_ch.valid && req_ch.ready;
      if (in_xfer) track_touch(req_ch.op, req_ch.sample);
    end else begin
      in_xfer = 1'b0;
    end
    drained = (pending_items.size() == 0) && !req_ch.valid && (expected_reports.size() == 0);
  end

  // input driver
  always @(negedge clk) begin
    touch_item_t nxt;
    if (!rst && (!req_ch.valid || in_xfer)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        req_ch.valid  <= 1'b1;
        req_ch.op     <= nxt.op;
        req_ch.sample <= nxt.sample;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // report receiver
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_sample_filter_unit: mismatch");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [SMP_W-1:0] smp);
    pending_items.push_back('{op: op, sample: smp});
    queued_items++;
  endtask

  function automatic int skew(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  task automatic queue_group(input int center, input int spread);
    int s;
    repeat (SAMPLES) begin
      if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 4095);
      else s = center + skew(spread);
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      push_item(OP_SAMPLE, SMP_W'(s));
    end
  endtask

  task automatic queue_touch_traffic(input int target);
    int goal, kind, cx, cy, spread, m, n;
    goal = queued_items + target;
    while (queued_items < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        // press: whole scans around one point, then release
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = $urandom_range(0, 300);
          default: spread = $urandom_range(0, 4);
        endcase
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: m = 0;
            1: m = 8;
            default: m = 120;
          endcase
          queue_group(cx, spread);
          queue_group(cy, spread);
          queue_group(cx + skew(m), spread);
          queue_group(cy + skew(m), spread);
          cx += skew(20);
          cy += skew(20);
        end
        if ($urandom_range(0, 1)) push_item(OP_ACK, SMP_W'($urandom));
        push_item(OP_PEN_UP, SMP_W'($urandom));
      end else if (kind < 90) begin
        push_item(2'($urandom_range(0, 3)), SMP_W'($urandom));
      end else begin
        // scan cut short by a release
        n = $urandom_range(1, 4 * SAMPLES - 1);
        repeat (n) push_item(OP_SAMPLE, SMP_W'($urandom));
        push_item(OP_PEN_UP, SMP_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (!drained);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RAW_MODE:     cfg_model.raw_mode     = value[0];
      REG_AGREE_WINDOW: cfg_model.agree_window = value[SMP_W-1:0];
      REG_X_GAIN:       cfg_model.x_gain       = value[GAIN_W-1:0];
      REG_X_OFFSET:     cfg_model.x_offset     = value[OFS_W-1:0];
      REG_Y_GAIN:       cfg_model.y_gain       = value[GAIN_W-1:0];
      REG_Y_OFFSET:     cfg_model.y_offset     = value[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_filter(input int raw, input int window, input int xg, input int xo,
                                input int yg, input int yo);
    wait_drained();
    repeat (DRAIN_GAP) @(negedge clk);
    apb_write(REG_RAW_MODE, 32'(raw));
    apb_write(REG_AGREE_WINDOW, 32'(window));
    apb_write(REG_X_GAIN, 32'(xg));
    apb_write(REG_X_OFFSET, 32'(xo));
    apb_write(REG_Y_GAIN, 32'(yg));
    apb_write(REG_Y_OFFSET, 32'(yo));
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_SAMPLE;
    req_ch.sample = '0;
    rsp_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 61;
    push_item(OP_ACK, 12'hfff);
    push_item(OP_PEN_UP, 12'h000);
    push_item(OP_NONE, 12'hfff);
    foreach (directed_scan[i]) push_item(OP_SAMPLE, SMP_W'(directed_scan[i]));
    push_item(OP_ACK, 12'h000);
    push_item(OP_PEN_UP, 12'hfff);

    program_filter(1, 4095, 65536, 0, 65536, 0);
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    queue_touch_traffic(50);
    wait_drained();
    queue_touch_traffic(50);

    program_filter(0, 1, -131072, 32767, 131072, -32768);
    send_idle_pct = 61;
    recv_idle_pct = 30;
    queue_touch_traffic(100);

    program_filter(0, 0, -262144, -32768, 262143, 32767);
    queue_touch_traffic(80);

    program_filter(0, 60, 262143, int'($urandom_range(0, 65535)) - 32768,
                   -262144, int'($urandom_range(0, 65535)) - 32768);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_touch_traffic(100);

    program_filter($urandom_range(0, 1),
                   $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(1, 4095),
                   int'($urandom_range(0, 524287)) - 262144,
                   int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 524287)) - 262144,
                   int'($urandom_range(0, 65535)) - 32768);
    queue_touch_traffic(100);

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("touch_sample_filter_unit: match");
    end else begin
      $display("touch_sample_filter_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tsf_pkg.sv
sv/tsf_in_if.sv
sv/tsf_out_if.sv
sv/tsf_ctrl.sv
sv/tsf_dp.sv
sv/touch_sample_filter_unit.sv
tb/tb_touch_sample_filter_unit.sv
